// File: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the packed array search and delete block.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND      = 2'd0,
      OP_REMOVE_LAST = 2'd1,
      OP_FIND        = 2'd2,
      OP_DELETE      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

endpackage

// File: rtl/psd_if.sv
// ----------------------------------------------------------------------------
// psd_if
// Request and response channels of the packed array search and delete block.
// ----------------------------------------------------------------------------
interface psd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [psd_pkg::OP_W-1:0]              op;
   logic signed [psd_pkg::VALUE_W-1:0]    value;

   modport source (output valid, op, value, input ready);
   modport sink   (input valid, op, value, output ready);
endinterface

interface psd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [psd_pkg::STATUS_W-1:0]          status;
   logic [psd_pkg::POS_W-1:0]             position;
   logic [psd_pkg::COUNT_W-1:0]           entry_count;

   modport source (output valid, status, position, entry_count, input ready);
   modport sink   (input valid, status, position, entry_count, output ready);
endinterface

// File: rtl/packed_array_search_delete_top.sv
// ----------------------------------------------------------------------------
// packed_array_search_delete_top
// Packed list of signed 32-bit values in a one-port-read, one-port-write RAM
// with append, remove last, linear find and delete with shift down.
//
//   channel    dir   words                        handshake
//   req_chan   in    op, value                    valid / ready
//   rsp_chan   out   status, position, count      valid / ready
//
// Append and remove last go from accept through the done state to the response
// register. Find and delete scan the list, and delete then shifts the tail down:
// the scan and the shift each stream one entry a cycle through the registered
// RAM read port. One word is handled at a time; the next word is taken the
// cycle after the response register loads, and loading waits while an earlier
// response is unread. Synchronous reset empties the list at once, the RAM
// itself is not cleared.
// ----------------------------------------------------------------------------
module packed_array_search_delete_top (
   input  logic       clock,
   input  logic       reset,
   psd_req_if.sink    req_chan,
   psd_rsp_if.source  rsp_chan
);

   localparam logic [psd_pkg::CNT_W-1:0] CAP_COUNT = psd_pkg::CNT_W'(psd_pkg::CAPACITY);

   logic signed [psd_pkg::VALUE_W-1:0] entry_mem [psd_pkg::CAPACITY];
   logic signed [psd_pkg::VALUE_W-1:0] rd_data_ff;

   logic                               mem_we;
   logic [psd_pkg::IDX_W-1:0]          mem_waddr;
   logic signed [psd_pkg::VALUE_W-1:0] mem_wdata;
   logic [psd_pkg::IDX_W-1:0]          mem_raddr;

   psd_pkg::state_type                 state_ff, state_in;
   psd_pkg::op_type                    op_ff, op_in;
   logic signed [psd_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [psd_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [psd_pkg::CNT_W-1:0]          scan_ff, scan_in;
   logic                               pend_ff, pend_in;
   logic [psd_pkg::IDX_W-1:0]          pend_idx_ff, pend_idx_in;
   logic [psd_pkg::IDX_W-1:0]          pos_ff, pos_in;
   psd_pkg::status_type                status_ff, status_in;

   logic                               rsp_valid_ff;
   psd_pkg::status_type                rsp_status_ff;
   logic [psd_pkg::IDX_W-1:0]          rsp_pos_ff;
   logic [psd_pkg::CNT_W-1:0]          rsp_count_ff;
   logic                               load_rsp;

   logic [psd_pkg::CNT_W-1:0]          count_dec;
   logic                               hit;

   // ram: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   assign count_dec = count_ff - 1'b1;
   assign hit       = pend_ff && (rd_data_ff == value_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      mem_we      = 1'b0;
      mem_waddr   = pend_idx_ff - 1'b1;
      mem_wdata   = rd_data_ff;
      mem_raddr   = scan_ff[psd_pkg::IDX_W-1:0];
      load_rsp    = 1'b0;
      req_chan.ready = (state_ff == psd_pkg::S_IDLE);

      unique case (state_ff)
         psd_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = psd_pkg::op_type'(req_chan.op);
               value_in  = req_chan.value;
               pos_in    = '0;
               status_in = psd_pkg::STAT_OK;
               state_in  = psd_pkg::S_DONE;
               unique case (psd_pkg::op_type'(req_chan.op))
                  psd_pkg::OP_APPEND: begin
                     if (count_ff == CAP_COUNT) begin
                        status_in = psd_pkg::STAT_FULL;
                     end else begin
                        pos_in    = count_ff[psd_pkg::IDX_W-1:0];
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[psd_pkg::IDX_W-1:0];
                        mem_wdata = req_chan.value;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  psd_pkg::OP_REMOVE_LAST: begin
                     if (count_ff == '0) begin
                        status_in = psd_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_dec;
                        pos_in   = count_dec[psd_pkg::IDX_W-1:0];
                     end
                  end
                  psd_pkg::OP_FIND, psd_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = psd_pkg::STAT_NOT_FOUND;
                     end else begin
                        scan_in  = '0;
                        state_in = psd_pkg::S_SEARCH;
                     end
                  end
               endcase
            end
         end

         psd_pkg::S_SEARCH: begin
            // compare the word read last cycle while the next read goes out
            priority if (hit) begin
               pos_in    = pend_idx_ff;
               status_in = psd_pkg::STAT_OK;
               if (op_ff == psd_pkg::OP_DELETE) begin
                  scan_in  = psd_pkg::CNT_W'(pend_idx_ff) + 1'b1;
                  state_in = psd_pkg::S_SHIFT;
               end else begin
                  state_in = psd_pkg::S_DONE;
               end
            end else if (scan_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[psd_pkg::IDX_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               pos_in    = '0;
               status_in = psd_pkg::STAT_NOT_FOUND;
               state_in  = psd_pkg::S_DONE;
            end else begin
               pend_in = 1'b0;
            end
         end

         psd_pkg::S_SHIFT: begin
            // reads run one entry ahead of the writes, so no overlap
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (scan_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[psd_pkg::IDX_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               count_in = count_dec;
               state_in = psd_pkg::S_DONE;
            end
         end

         psd_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = psd_pkg::S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psd_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= load_rsp || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.position    = psd_pkg::POS_W'(rsp_pos_ff);
   assign rsp_chan.entry_count = psd_pkg::COUNT_W'(rsp_count_ff);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed list with append, remove last, find and
// delete. A directed opening walks the corner cases, then a fill to capacity,
// then random bursts that grow, shrink or churn the list. Every accepted word
// runs through a shadow copy of the list, and each response is checked field
// by field against the oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      psd_pkg::op_type                  op;
      logic [psd_pkg::VALUE_W-1:0]      value;
   } list_cmd_type;

   typedef struct {
      psd_pkg::status_type              status;
      logic [psd_pkg::POS_W-1:0]        position;
      logic [psd_pkg::COUNT_W-1:0]      entry_count;
   } list_reply_type;

   localparam int RANDOM_OPS = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psd_req_if req_bus ();
   psd_rsp_if rsp_bus ();

   packed_array_search_delete_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   list_cmd_type                pending_ops[$];
   list_reply_type              predicted_replies[$];
   logic [psd_pkg::VALUE_W-1:0] shadow_list[psd_pkg::CAPACITY];
   int                          shadow_len = 0;
   logic [psd_pkg::VALUE_W-1:0] value_pool[12];

   int  total_ops     = 0;
   int  ops_accepted  = 0;
   int  error_count   = 0;
   int  full_refused  = 0;
   int  empty_refused = 0;
   int  misses        = 0;
   int  deletes_done  = 0;
   int  peak_len      = 0;
   logic req_taken    = 1'b0;

   // shadow list: applies one word and returns the reply it must produce
   function automatic list_reply_type apply_list_op(list_cmd_type cmd);
      list_reply_type r;
      int hit;
      int i;
      r.status   = psd_pkg::STAT_OK;
      r.position = '0;
      case (cmd.op)
         psd_pkg::OP_APPEND: begin
            if (shadow_len >= psd_pkg::CAPACITY) begin
               r.status = psd_pkg::STAT_FULL;
            end else begin
               r.position = shadow_len[psd_pkg::POS_W-1:0];
               shadow_list[shadow_len] = cmd.value;
               shadow_len++;
            end
         end
         psd_pkg::OP_REMOVE_LAST: begin
            if (shadow_len == 0) begin
               r.status = psd_pkg::STAT_EMPTY;
            end else begin
               shadow_len--;
               r.position = shadow_len[psd_pkg::POS_W-1:0];
            end
         end
         default: begin
            hit = -1;
            for (i = 0; i < shadow_len; i++)
               if (hit < 0 && shadow_list[i] == cmd.value) hit = i;
            if (hit < 0) begin
               r.status = psd_pkg::STAT_NOT_FOUND;
            end else begin
               r.position = hit[psd_pkg::POS_W-1:0];
               if (cmd.op == psd_pkg::OP_DELETE) begin
                  for (i = hit; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i + 1];
                  shadow_len--;
               end
            end
         end
      endcase
      r.entry_count = shadow_len[psd_pkg::COUNT_W-1:0];
      return r;
   endfunction

   // no stalls on either side over a stretch in the middle of the run
   function automatic bit take_break();
      if (ops_accepted >= 300 && ops_accepted < 500) return 1'b0;
      return $urandom_range(99) < 13;
   endfunction

   function automatic logic [psd_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 80) return value_pool[$urandom_range(11)];
      return $urandom;
   endfunction

   task automatic queue_op(psd_pkg::op_type op, logic [psd_pkg::VALUE_W-1:0] value);
      list_cmd_type cmd;
      cmd.op    = op;
      cmd.value = value;
      pending_ops.push_back(cmd);
   endtask

   task automatic check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   // request driver and response back-pressure, both on the falling edge
   always @(negedge clock) begin : drive_channels
      list_cmd_type next_cmd;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_ops.size() > 0 && !take_break()) begin
               next_cmd = pending_ops.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op    <= next_cmd.op;
               req_bus.value <= next_cmd.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= !take_break();
      end
   end

   // monitor: check responses first, then predict the word accepted this edge
   always @(posedge clock) begin : watch_channels
      list_cmd_type   seen_cmd;
      list_reply_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_replies.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, %s %0d %0d %0d",
                        $time, "got status, position, count", rsp_bus.status,
                        rsp_bus.position, rsp_bus.entry_count);
            end else begin
               want = predicted_replies.pop_front();
               check_field("status", want.status, rsp_bus.status);
               check_field("position", want.position, rsp_bus.position);
               check_field("entry_count", want.entry_count, rsp_bus.entry_count);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_cmd.op    = psd_pkg::op_type'(req_bus.op);
            seen_cmd.value = req_bus.value;
            want = apply_list_op(seen_cmd);
            predicted_replies.push_back(want);
            ops_accepted++;
            case (want.status)
               psd_pkg::STAT_FULL:      full_refused++;
               psd_pkg::STAT_EMPTY:     empty_refused++;
               psd_pkg::STAT_NOT_FOUND: misses++;
               default:                 if (seen_cmd.op == psd_pkg::OP_DELETE) deletes_done++;
            endcase
            if (shadow_len > peak_len) peak_len = shadow_len;
         end
      end
   end

   initial begin : run_test
      int seg_len;
      int mode;
      int roll;
      int n;
      req_bus.valid = 1'b0;
      req_bus.op    = psd_pkg::OP_APPEND;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (n = 4; n < 12; n++) value_pool[n] = $urandom;

      // corner cases on an empty list
      queue_op(psd_pkg::OP_REMOVE_LAST, $urandom);
      queue_op(psd_pkg::OP_FIND, 32'h0000_0000);
      queue_op(psd_pkg::OP_DELETE, 32'h0000_0000);
      // extremes, with a duplicate of the first entry at the end
      queue_op(psd_pkg::OP_APPEND, 32'h8000_0000);
      queue_op(psd_pkg::OP_APPEND, 32'h7FFF_FFFF);
      queue_op(psd_pkg::OP_APPEND, 32'h0000_0000);
      queue_op(psd_pkg::OP_APPEND, 32'hFFFF_FFFF);
      queue_op(psd_pkg::OP_APPEND, 32'h8000_0000);
      queue_op(psd_pkg::OP_FIND, 32'h8000_0000);
      queue_op(psd_pkg::OP_FIND, 32'hFFFF_FFFF);
      // one bit away from a stored value must miss
      queue_op(psd_pkg::OP_FIND, 32'h8000_0001);
      queue_op(psd_pkg::OP_FIND, 32'h7FFF_FFFE);
      queue_op(psd_pkg::OP_DELETE, 32'h8000_0000);
      queue_op(psd_pkg::OP_DELETE, 32'hFFFF_FFFF);
      queue_op(psd_pkg::OP_DELETE, 32'h8000_0000);
      queue_op(psd_pkg::OP_DELETE, 32'h1234_5678);
      queue_op(psd_pkg::OP_REMOVE_LAST, 32'hFFFF_FFFF);
      queue_op(psd_pkg::OP_REMOVE_LAST, 32'h0000_0000);
      queue_op(psd_pkg::OP_REMOVE_LAST, 32'h0000_0000);

      // fill to capacity, refuse twice, then work on the full list
      for (n = 0; n < psd_pkg::CAPACITY + 2; n++) queue_op(psd_pkg::OP_APPEND, pick_value());
      queue_op(psd_pkg::OP_FIND, value_pool[$urandom_range(11)]);
      queue_op(psd_pkg::OP_DELETE, value_pool[$urandom_range(11)]);
      queue_op(psd_pkg::OP_APPEND, $urandom);
      queue_op(psd_pkg::OP_APPEND, $urandom);
      queue_op(psd_pkg::OP_REMOVE_LAST, $urandom);
      queue_op(psd_pkg::OP_FIND, $urandom);

      // random bursts that grow, shrink or churn the list
      while (pending_ops.size() < RANDOM_OPS) begin
         seg_len = $urandom_range(80, 20);
         mode    = $urandom_range(2);
         for (n = 0; n < seg_len; n++) begin
            roll = $urandom_range(99);
            case (mode)
               0:       roll = (roll < 70) ? 0 : (roll < 75) ? 1 : (roll < 90) ? 2 : 3;
               1:       roll = (roll < 15) ? 0 : (roll < 45) ? 1 : (roll < 65) ? 2 : 3;
               default: roll = (roll < 30) ? 0 : (roll < 50) ? 1 : (roll < 75) ? 2 : 3;
            endcase
            case (roll)
               0:       queue_op(psd_pkg::OP_APPEND, pick_value());
               1:       queue_op(psd_pkg::OP_REMOVE_LAST, $urandom);
               2:       queue_op(psd_pkg::OP_FIND, pick_value());
               default: queue_op(psd_pkg::OP_DELETE, pick_value());
            endcase
         end
      end
      total_ops = pending_ops.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (ops_accepted == total_ops && predicted_replies.size() == 0);
      repeat (200) @(posedge clock);

      $display("ran %0d list operations, %0d deletes with shift, %0d misses, peak length %0d",
               ops_accepted, deletes_done, misses, peak_len);
      $display("refused %0d appends on a full list and %0d removals on an empty one",
               full_refused, empty_refused);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: packed_array_search_delete_top.f
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/packed_array_search_delete_top.sv
tb/tb.sv
